// ===== rtl/rrq_pkg.sv =====
`timescale 1ns / 1ps
package rrq_pkg;

  localparam int MAX_THREADS = 64;
  localparam int NUM_CPUS    = 4;
  localparam int TW          = $clog2(MAX_THREADS);
  localparam int QW          = $clog2(NUM_CPUS);
  localparam int CNTW        = $clog2(MAX_THREADS + 1);
  localparam logic [7:0] DEFAULT_SLICE = 8'd10;
  localparam logic [2:0] DEFAULT_CPUS  = 3'd4;

  localparam logic [2:0] CMD_ENQUEUE = 3'd0;
  localparam logic [2:0] CMD_DEQUEUE = 3'd1;
  localparam logic [2:0] CMD_PICK    = 3'd2;
  localparam logic [2:0] CMD_TICK    = 3'd3;
  localparam logic [2:0] CMD_SELECT  = 3'd4;

  localparam logic REG_TIMESLICE = 1'b0;
  localparam logic REG_CPUS      = 1'b1;

  typedef struct packed {
    logic [2:0]    cmd;
    logic [TW-1:0] thread_num;
    logic          thread_present;
    logic [QW-1:0] cpu_index;
    logic          cpu_known;
    logic [3:0]    affinity_mask;
  } in_item_t;

  typedef struct packed {
    logic          head_valid;
    logic [TW-1:0] head_thread;
    logic          reschedule;
    logic          removed;
    logic [QW-1:0] chosen_cpu;
  } result_t;

  // Update request to one queue cell.
  typedef struct packed {
    logic          set_head;
    logic [TW-1:0] head_val;
    logic          set_tail;
    logic [TW-1:0] tail_val;
    logic          inc;
    logic          dec;
  } cell_upd_t;

  typedef struct packed {
    logic [TW-1:0]   head;
    logic [TW-1:0]   tail;
    logic [CNTW-1:0] count;
  } cell_stat_t;

  // Best-so-far token handed from cell to cell during CPU selection.
  typedef struct packed {
    logic            found;
    logic [QW-1:0]   best;
    logic [CNTW-1:0] load;
  } sel_tok_t;

endpackage

// ===== rtl/rrq_cpu_cell.sv =====
`timescale 1ns / 1ps
module rrq_cpu_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic [rrq_pkg::QW-1:0] idx,
  input  logic              allowed,
  input  rrq_pkg::cell_upd_t  upd,
  input  rrq_pkg::sel_tok_t   tok_in,
  output rrq_pkg::sel_tok_t   tok_out,
  output rrq_pkg::cell_stat_t stat
);
  import rrq_pkg::*;

  logic [TW-1:0]   head;
  logic [TW-1:0]   tail;
  logic [CNTW-1:0] count;

  always_ff @(posedge clk) begin
    if (upd.set_head) head <= upd.head_val;
    if (upd.set_tail) tail <= upd.tail_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (upd.inc) begin
      count <= count + CNTW'(1);
    end else if (upd.dec) begin
      count <= count - CNTW'(1);
    end
  end

  // The token is replaced when this queue is allowed and either no queue has been found yet or it is strictly lighter.
  always_comb begin
    tok_out = tok_in;
    if (allowed && (!tok_in.found || count < tok_in.load)) begin
      tok_out.found = 1'b1;
      tok_out.best  = idx;
      tok_out.load  = count;
    end
  end

  assign stat = '{head: head, tail: tail, count: count};
endmodule

// ===== rtl/rrq_ctrl.sv =====
`timescale 1ns / 1ps
module rrq_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  rrq_pkg::in_item_t        in_item,
  input  logic [7:0]               slice_ticks,
  input  rrq_pkg::cell_stat_t      stat,
  input  logic [rrq_pkg::QW-1:0]   sel_cpu,
  output logic [rrq_pkg::QW-1:0]   q_sel,
  output rrq_pkg::cell_upd_t       upd,
  output logic                     busy,
  output logic                     done,
  output rrq_pkg::result_t         result
);
  import rrq_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_ENQ_LINK = 10'b0000000010,
    S_DQ_RD    = 10'b0000000100,
    S_DQ_CHK   = 10'b0000001000,
    S_DQ_CLR   = 10'b0000010000,
    S_PK_RD    = 10'b0000100000,
    S_PK_CHK   = 10'b0001000000,
    S_PK_TAIL  = 10'b0010000000,
    S_TK_RD    = 10'b0100000000,
    S_TK_CHK   = 10'b1000000000
  } state_t;

  state_t          state, state_next;
  logic [QW-1:0]   q, q_next;
  logic [TW-1:0]   t, t_next;
  logic [TW-1:0]   cur, cur_next;
  logic [TW-1:0]   prev, prev_next;
  logic [CNTW-1:0] i, i_next;
  logic            fin;
  result_t         res_next;

  logic [TW-1:0] link_mem [MAX_THREADS];
  logic [7:0]    slice_mem [MAX_THREADS];
  logic [MAX_THREADS-1:0] slice_vld;
  logic          link_we, slice_we;
  logic [TW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
  logic [TW-1:0] slice_waddr, slice_raddr;
  logic [7:0]    slice_wdata, slice_rraw, slice_rdata;
  logic          slice_rvld;

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_rdata <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (slice_we) slice_mem[slice_waddr] <= slice_wdata;
    slice_rraw <= slice_mem[slice_raddr];
    slice_rvld <= slice_vld[slice_raddr];
  end

  // A slice never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_vld <= '0;
    end else if (slice_we) begin
      slice_vld[slice_waddr] <= 1'b1;
    end
  end

  assign slice_rdata = slice_rvld ? slice_rraw : 8'd0;

  always_comb begin
    q_sel = q;
    if (state == S_IDLE) begin
      q_sel = (in_item.cmd == CMD_DEQUEUE && !in_item.cpu_known) ? '0 : in_item.cpu_index;
    end
  end

  always_comb begin
    state_next  = state;
    q_next      = q;
    t_next      = t;
    cur_next    = cur;
    prev_next   = prev;
    i_next      = i;
    fin         = 1'b0;
    res_next    = '0;
    upd         = '0;
    link_we     = 1'b0;
    link_waddr  = '0;
    link_wdata  = '0;
    link_raddr  = cur;
    slice_we    = 1'b0;
    slice_waddr = '0;
    slice_wdata = slice_ticks;
    slice_raddr = cur;
    case (state)
      S_IDLE: begin
        if (start) begin
          q_next = q_sel;
          t_next = in_item.thread_num;
          case (in_item.cmd)
            CMD_ENQUEUE: begin
              if (stat.count == CNTW'(MAX_THREADS)) begin
                fin = 1'b1;
              end else begin
                link_we      = 1'b1;
                link_waddr   = in_item.thread_num;
                slice_we     = 1'b1;
                slice_waddr  = in_item.thread_num;
                upd.set_tail = 1'b1;
                upd.tail_val = in_item.thread_num;
                upd.inc      = 1'b1;
                if (stat.count == '0) begin
                  upd.set_head = 1'b1;
                  upd.head_val = in_item.thread_num;
                  fin          = 1'b1;
                end else begin
                  prev_next  = stat.tail;
                  state_next = S_ENQ_LINK;
                end
              end
            end
            CMD_DEQUEUE: begin
              if (stat.count == '0) begin
                fin = 1'b1;
              end else begin
                cur_next   = stat.head;
                i_next     = '0;
                state_next = S_DQ_RD;
              end
            end
            CMD_PICK: begin
              if (stat.count == '0) begin
                fin = 1'b1;
              end else begin
                cur_next   = stat.head;
                state_next = S_PK_RD;
              end
            end
            CMD_TICK: begin
              if (!in_item.thread_present) begin
                fin = 1'b1;
              end else begin
                state_next = S_TK_RD;
              end
            end
            CMD_SELECT: begin
              fin                 = 1'b1;
              res_next.chosen_cpu = sel_cpu;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_ENQ_LINK: begin
        link_we    = 1'b1;
        link_waddr = prev;
        link_wdata = t;
        fin        = 1'b1;
      end
      S_DQ_RD: begin
        link_raddr = cur;
        state_next = S_DQ_CHK;
      end
      S_DQ_CHK: begin
        if (cur == t) begin
          if (i == '0) begin
            upd.set_head = 1'b1;
            upd.head_val = link_rdata;
          end else begin
            link_we    = 1'b1;
            link_waddr = prev;
            link_wdata = link_rdata;
          end
          if (stat.tail == cur && i != '0) begin
            upd.set_tail = 1'b1;
            upd.tail_val = prev;
          end
          upd.dec    = 1'b1;
          state_next = S_DQ_CLR;
        end else begin
          prev_next = cur;
          cur_next  = link_rdata;
          i_next    = i + CNTW'(1);
          if (i + CNTW'(1) == stat.count) begin
            fin = 1'b1;
          end else begin
            state_next = S_DQ_RD;
          end
        end
      end
      S_DQ_CLR: begin
        link_we          = 1'b1;
        link_waddr       = t;
        fin              = 1'b1;
        res_next.removed = 1'b1;
      end
      S_PK_RD: begin
        link_raddr  = cur;
        slice_raddr = cur;
        state_next  = S_PK_CHK;
      end
      S_PK_CHK: begin
        res_next.head_valid  = 1'b1;
        res_next.head_thread = cur;
        if (slice_rdata == 8'd0) begin
          slice_we    = 1'b1;
          slice_waddr = cur;
          if (stat.count > CNTW'(1)) begin
            upd.set_head = 1'b1;
            upd.head_val = link_rdata;
            link_we      = 1'b1;
            link_waddr   = cur;
            prev_next    = stat.tail;
            cur_next     = link_rdata;
            t_next       = cur;
            state_next   = S_PK_TAIL;
          end else begin
            fin = 1'b1;
          end
        end else begin
          fin = 1'b1;
        end
      end
      S_PK_TAIL: begin
        // cur now holds the new head and t the rotated thread.
        link_we              = 1'b1;
        link_waddr           = prev;
        link_wdata           = t;
        upd.set_tail         = 1'b1;
        upd.tail_val         = t;
        fin                  = 1'b1;
        res_next.head_valid  = 1'b1;
        res_next.head_thread = cur;
      end
      S_TK_RD: begin
        slice_raddr = t;
        state_next  = S_TK_CHK;
      end
      S_TK_CHK: begin
        fin = 1'b1;
        if (slice_rdata != 8'd0) begin
          slice_we            = 1'b1;
          slice_waddr         = t;
          slice_wdata         = slice_rdata - 8'd1;
          res_next.reschedule = (slice_rdata == 8'd1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) state_next = S_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    q    <= q_next;
    t    <= t_next;
    cur  <= cur_next;
    prev <= prev_next;
    i    <= i_next;
    if (fin) result <= res_next;
  end

  assign busy = (state != S_IDLE);
endmodule

// ===== rtl/round_robin_run_queue_unit.sv =====
`timescale 1ns / 1ps
// Round-robin run queue unit. A command transfer is taken when start is high
// and busy is low; its single result appears on result with done high for
// exactly one cycle, and the receiver cannot stall it. Select, unknown
// commands, a tick with no current thread and commands on an empty queue
// finish straight from idle; an enqueue into a partly filled queue adds a link
// write, a tick on a present thread reads and then updates its slice, and a
// head pick reads and checks the head, with a tail step when an expired head
// rotates to the tail. A dequeue walks its queue with a read state and a check
// state per entry visited, plus a clearing step when the thread is found. This
// stepping is set by the registered read of the next-link and slice memories.
// Slices read as zero after reset through per-thread valid bits, so no
// clearing pass is needed. A row of four queue cells holds head, tail and
// count per CPU and passes a best-so-far token for the least-loaded choice.
module round_robin_run_queue_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rrq_pkg::in_item_t in_item,
  output logic              busy,
  output logic              done,
  output rrq_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import rrq_pkg::*;

  logic [7:0] timeslice_ticks;
  logic [2:0] cpus_online;

  // A write transfer completes on the access cycle; pready is tied high.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeslice_ticks <= DEFAULT_SLICE;
      cpus_online     <= DEFAULT_CPUS;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_TIMESLICE: timeslice_ticks <= pwdata[7:0];
        REG_CPUS:      cpus_online     <= pwdata[2:0];
        default:       ;
      endcase
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CPUS) ? {29'd0, cpus_online} : {24'd0, timeslice_ticks};

  logic [QW-1:0] q_sel;
  cell_upd_t     upd;
  cell_stat_t    stats [NUM_CPUS];
  sel_tok_t      toks  [NUM_CPUS+1];

  assign toks[0] = '0;

  // Each cell sees only the update aimed at its own queue.
  for (genvar c = 0; c < NUM_CPUS; c++) begin : g_cell
    rrq_cpu_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (QW'(c)),
      .allowed (in_item.affinity_mask[c] && (cpus_online > 3'(c))),
      .upd     ((q_sel == QW'(c)) ? upd : cell_upd_t'('0)),
      .tok_in  (toks[c]),
      .tok_out (toks[c+1]),
      .stat    (stats[c])
    );
  end

  rrq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .in_item     (in_item),
    .slice_ticks (timeslice_ticks),
    .stat        (stats[q_sel]),
    .sel_cpu     (toks[NUM_CPUS].best),
    .q_sel       (q_sel),
    .upd         (upd),
    .busy        (busy),
    .done        (done),
    .result      (result)
  );
endmodule

// ===== rtl/rrq_checker.sv =====
`timescale 1ns / 1ps
module rrq_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input rrq_pkg::result_t result,
  input logic             pready
);
  import rrq_pkg::*;

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a command in flight");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted command");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.removed && result.reschedule))
    else $error("result carries two command kinds");

  a_ready: assert property (@(posedge clk) pready)
    else $error("pready dropped");
endmodule

bind round_robin_run_queue_unit rrq_checker u_rrq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result),
  .pready (pready)
);

// ===== bench/tb_round_robin_run_queue_unit.sv =====
`timescale 1ns / 1ps
module tb_round_robin_run_queue_unit;
  import rrq_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  in_item_t    in_item = '0;
  logic        busy;
  logic        done;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  round_robin_run_queue_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item), .busy(busy),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // The clock toggles every half period of 10 ns.
  always #10 clk = ~clk;

  // Shadow copy of the scheduler state that the predictor keeps in step
  // with each accepted command transfer.
  logic [7:0]      slice_ticks;
  logic [2:0]      online_cpus;
  logic [TW-1:0]   link_of [MAX_THREADS];
  logic [7:0]      slice_of [MAX_THREADS];
  logic [TW-1:0]   head_of [NUM_CPUS];
  logic [TW-1:0]   tail_of [NUM_CPUS];
  int unsigned     count_of [NUM_CPUS];

  result_t pending_results[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  localparam int WATCHDOG_LIMIT = 20000;

  // Works out the one result of a command and updates the shadow state.
  function automatic result_t schedule_cmd(in_item_t it);
    result_t       r;
    logic [QW-1:0] q, best;
    logic [TW-1:0] cur, prev, nxt, h;
    int unsigned   best_load;
    int            lim;
    bit            found;
    r = '0;
    q = it.cpu_index;
    case (it.cmd)
      CMD_ENQUEUE: begin
        if (count_of[q] < MAX_THREADS) begin
          link_of[it.thread_num] = '0;
          slice_of[it.thread_num] = slice_ticks;
          if (count_of[q] == 0) head_of[q] = it.thread_num;
          else link_of[tail_of[q]] = it.thread_num;
          tail_of[q] = it.thread_num;
          count_of[q]++;
        end
      end
      CMD_DEQUEUE: begin
        if (!it.cpu_known) q = '0;
        prev = '0;
        cur = head_of[q];
        for (int i = 0; i < count_of[q]; i++) begin
          if (cur == it.thread_num) begin
            nxt = link_of[cur];
            if (i == 0) head_of[q] = nxt;
            else link_of[prev] = nxt;
            if (tail_of[q] == cur && i > 0) tail_of[q] = prev;
            count_of[q]--;
            link_of[it.thread_num] = '0;
            r.removed = 1'b1;
            break;
          end
          prev = cur;
          cur = link_of[cur];
        end
      end
      CMD_PICK: begin
        if (count_of[q] != 0) begin
          h = head_of[q];
          if (slice_of[h] == 0) begin
            // An expired head moves to the tail unless it is alone.
            if (count_of[q] > 1) begin
              head_of[q] = link_of[h];
              link_of[h] = '0;
              link_of[tail_of[q]] = h;
              tail_of[q] = h;
            end
            slice_of[h] = slice_ticks;
          end
          r.head_valid = 1'b1;
          r.head_thread = head_of[q];
        end
      end
      CMD_TICK: begin
        if (it.thread_present && slice_of[it.thread_num] != 0) begin
          slice_of[it.thread_num]--;
          r.reschedule = (slice_of[it.thread_num] == 0);
        end
      end
      CMD_SELECT: begin
        lim = (int'(online_cpus) > NUM_CPUS) ? NUM_CPUS : int'(online_cpus);
        found = 1'b0;
        best = '0;
        best_load = 0;
        for (int c = 0; c < lim; c++) begin
          if (it.affinity_mask[c] && (!found || count_of[c] < best_load)) begin
            best = QW'(c);
            best_load = count_of[c];
            found = 1'b1;
          end
        end
        r.chosen_cpu = best;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Checks every result strobe against the oldest expected result.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (result !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", e, result);
        end
      end
    end
  end

  // The watchdog counts cycles in which no transfer happens.
  always @(posedge clk) begin
    if ((start && !busy) || done || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("round_robin_run_queue_unit test failed");
      $finish;
    end
  end

  // A register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (idx == REG_TIMESLICE) slice_ticks = value[7:0];
    else online_cpus = value[2:0];
  endtask

  // Sends one command; start stays high until the transfer is taken.
  task automatic send_cmd(input in_item_t it, input int gap);
    repeat (gap) @(negedge clk);
    start = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
    pending_results.push_back(schedule_cmd(it));
    @(negedge clk);
    start = 1'b0;
  endtask

  // Waits until every result has come, then waits on so that the block is
  // surely idle, and returns at a falling edge.
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_item_t make_cmd(logic [2:0] c, int t, int q, bit present,
                                        bit known, logic [3:0] mask);
    in_item_t it;
    it.cmd = c; it.thread_num = TW'(t); it.cpu_index = QW'(q);
    it.thread_present = present; it.cpu_known = known; it.affinity_mask = mask;
    return it;
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'($urandom));
    // Most commands are legal ones, with a few unknown codes.
    it.cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
    // A small pool of threads makes dequeue hits and slice expiry common.
    if ($urandom_range(0, 3) != 0) it.thread_num = TW'($urandom_range(0, 7));
    if ($urandom_range(0, 3) != 0) it.thread_present = 1'b1;
    return it;
  endfunction

  // Extremes of the fields, every command and most special cases.
  task automatic test_directed();
    send_cmd(make_cmd(CMD_PICK, 0, 0, 0, 0, 0), 0);           // empty queue
    send_cmd(make_cmd(CMD_DEQUEUE, 5, 0, 0, 1, 0), 0);        // absent thread
    send_cmd(make_cmd(CMD_TICK, 63, 3, 1, 1, 4'hF), 0);       // zero slice
    send_cmd(make_cmd(CMD_ENQUEUE, 63, 3, 1, 1, 4'hF), 0);
    send_cmd(make_cmd(CMD_ENQUEUE, 0, 3, 0, 0, 0), 1);
    send_cmd(make_cmd(CMD_ENQUEUE, 63, 3, 0, 0, 0), 0);       // duplicate
    send_cmd(make_cmd(CMD_SELECT, 0, 0, 0, 0, 4'hF), 0);
    send_cmd(make_cmd(CMD_SELECT, 0, 0, 0, 0, 4'h8), 0);
    send_cmd(make_cmd(CMD_SELECT, 0, 0, 0, 0, 4'h0), 0);      // none allowed
    send_cmd(make_cmd(CMD_PICK, 0, 3, 0, 0, 0), 0);
    send_cmd(make_cmd(CMD_TICK, 0, 0, 0, 0, 0), 0);           // no current thread
    for (int i = 0; i < 10; i++) send_cmd(make_cmd(CMD_TICK, 63, 0, 1, 0, 0), 0);
    send_cmd(make_cmd(CMD_PICK, 0, 3, 0, 0, 0), 0);           // rotation
    send_cmd(make_cmd(CMD_DEQUEUE, 63, 1, 0, 0, 0), 0);       // unknown cpu
    send_cmd(make_cmd(CMD_DEQUEUE, 0, 3, 0, 1, 0), 2);
    send_cmd(make_cmd(3'd7, 63, 3, 1, 1, 4'hF), 0);           // unknown command
    drain();
  endtask

  // A single expired head is only reloaded, then zero and full slices are used.
  task automatic test_slice_extremes();
    write_reg(REG_TIMESLICE, 32'd1);
    send_cmd(make_cmd(CMD_ENQUEUE, 9, 2, 0, 0, 0), 0);
    send_cmd(make_cmd(CMD_TICK, 9, 0, 1, 0, 0), 0);
    send_cmd(make_cmd(CMD_PICK, 0, 2, 0, 0, 0), 0);
    drain();
    write_reg(REG_TIMESLICE, 32'd0);
    send_cmd(make_cmd(CMD_TICK, 9, 0, 1, 0, 0), 0);
    send_cmd(make_cmd(CMD_ENQUEUE, 10, 2, 0, 0, 0), 0);
    send_cmd(make_cmd(CMD_TICK, 10, 0, 1, 0, 0), 0);
    drain();
    write_reg(REG_TIMESLICE, 32'd255);
    send_cmd(make_cmd(CMD_PICK, 0, 2, 0, 0, 0), 0);
    drain();
  endtask

  // Random commands over several register settings; the sender waits for
  // every result before each change and once in between.
  task automatic test_random();
    logic [2:0] cpus_list [4] = '{3'd1, 3'd4, 3'd0, 3'd2};
    logic [7:0] slice_list [4] = '{8'd2, 8'd1, 8'd255, 8'd10};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_CPUS, {29'd0, cpus_list[ph]});
      write_reg(REG_TIMESLICE, {24'd0, slice_list[ph]});
      for (int i = 0; i < 88; i++) begin
        // Every fourth stretch runs back to back with no gaps.
        send_cmd(random_cmd(), (i / 20) % 4 == 3 ? 0 : $urandom_range(0, 16));
        if (i == 44) drain();
      end
      drain();
    end
  endtask

  // Fill one queue to its limit so that an enqueue into a full queue is hit.
  task automatic test_full_queue();
    for (int i = 0; i <= MAX_THREADS; i++)
      send_cmd(make_cmd(CMD_ENQUEUE, i % MAX_THREADS, 1, 0, 0, 0), 0);
    send_cmd(make_cmd(CMD_DEQUEUE, 62, 1, 0, 1, 0), 0);
    send_cmd(make_cmd(CMD_SELECT, 0, 0, 0, 0, 4'h2), 0);
    drain();
  endtask

  initial begin
    slice_ticks = DEFAULT_SLICE;
    online_cpus = DEFAULT_CPUS;
    foreach (slice_of[i]) begin
      slice_of[i] = '0;
      link_of[i] = '0;
    end
    foreach (count_of[i]) begin
      count_of[i] = 0;
      head_of[i] = '0;
      tail_of[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_slice_extremes();
    test_random();
    test_full_queue();
    if (mismatches == 0) $display("round_robin_run_queue_unit test passed");
    else $display("round_robin_run_queue_unit test failed");
    $finish;
  end

endmodule
